/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry checks.
// Depends on a clock named clock and a synchronous reset named reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Same-cycle implication outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/casm_pkg.sv */
// Types, codes and helpers for the clock/alarm setting menu.
// Used by casm_core, casm_obuf and clock_alarm_setting_menu_top; no dependencies.
package casm_pkg;

   localparam int HOUR_W  = 5;
   localparam int SIXTY_W = 6;
   localparam int LED_W   = 17;

   localparam logic [SIXTY_W-1:0] HOUR_MAX   = 6'd23;
   localparam logic [SIXTY_W-1:0] MINUTE_MAX = 6'd59;
   localparam logic [SIXTY_W-1:0] STAT_LOW   = 6'd1;
   localparam logic [SIXTY_W-1:0] STAT_HIGH  = 6'd2;
   localparam logic [1:0]         STAT_OFF   = 2'd1;
   localparam logic [1:0]         STAT_ON    = 2'd2;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_LEFT  = 2'd1,
      OP_SAVE  = 2'd2,
      OP_RIGHT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_TIME  = 2'd1,
      MODE_ALARM = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ROW_NONE   = 2'd0,
      ROW_HOUR   = 2'd1,
      ROW_MINUTE = 2'd2,
      ROW_LAST   = 2'd3
   } row_type;

   typedef struct packed {
      logic                 alarm_enabled;
      logic [SIXTY_W-1:0]   alarm_minute;
      logic [HOUR_W-1:0]    alarm_hour;
      logic                 commit_alarm;
      logic [SIXTY_W-1:0]   set_second;
      logic [SIXTY_W-1:0]   set_minute;
      logic [HOUR_W-1:0]    set_hour;
      logic                 commit_time;
      logic [LED_W-1:0]     led_bits;
      logic [SIXTY_W-1:0]   edit_value;
      row_type              edit_row;
      mode_type             menu_mode;
   } rsp_type;

   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } buf_status_type;

   function automatic logic [LED_W-1:0] make_pattern(
      input logic [HOUR_W-1:0]  h,
      input logic [SIXTY_W-1:0] m,
      input logic [SIXTY_W-1:0] s
   );
      make_pattern = {h, m, s};
   endfunction

endpackage

/* rtl/casm_core.sv */
// Menu state and per-item result logic for the clock/alarm setting menu.
// Depends on casm_pkg.
module casm_core
   import casm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  op_type              op,
   input  logic [HOUR_W-1:0]   cur_hour,
   input  logic [SIXTY_W-1:0]  cur_minute,
   input  logic [SIXTY_W-1:0]  cur_second,
   output rsp_type             result
);

   mode_type           mode_ff, mode_in;
   row_type            row_ff, row_in;
   logic [SIXTY_W-1:0] edit_ff, edit_in;
   logic [SIXTY_W-1:0] cap_min_ff, cap_min_in;
   logic [SIXTY_W-1:0] cap_sec_ff, cap_sec_in;
   logic [HOUR_W-1:0]  pend_hour_ff, pend_hour_in;
   logic [SIXTY_W-1:0] pend_min_ff, pend_min_in;
   logic [SIXTY_W-1:0] pend_sec_ff, pend_sec_in;
   logic [HOUR_W-1:0]  alarm_hr_ff, alarm_hr_in;
   logic [SIXTY_W-1:0] alarm_min_ff, alarm_min_in;
   logic [1:0]         alarm_stat_ff, alarm_stat_in;
   logic [LED_W-1:0]   pattern_ff, pattern_in;
   logic               commit_time, commit_alarm;
   logic               show;

   logic [SIXTY_W-1:0] lo, hi;
   logic [SIXTY_W:0]   up_sum;
   logic [SIXTY_W-1:0] down_val, adj_up, adj_down;
   logic               last_row;

   assign last_row = (row_ff == ROW_LAST);

   // Mode/row transitions
   always_comb begin
      mode_in = mode_ff;
      row_in  = row_ff;
      case (mode_ff)
         MODE_IDLE: begin
            case (op)
               OP_LEFT: begin
                  mode_in = MODE_TIME;
                  row_in  = ROW_HOUR;
               end
               OP_RIGHT: begin
                  mode_in = MODE_ALARM;
                  row_in  = ROW_HOUR;
               end
               default: ;
            endcase
         end
         default: begin
            if (op == OP_SAVE) begin
               if (last_row) begin
                  mode_in = MODE_IDLE;
                  row_in  = ROW_NONE;
               end else begin
                  row_in = row_type'(row_ff + 2'd1);
               end
            end
         end
      endcase
   end

   // Bounds of the edited row and one-step wrap
   always_comb begin
      lo = '0;
      hi = MINUTE_MAX;
      if (row_ff == ROW_HOUR) begin
         hi = HOUR_MAX;
      end else if (last_row && mode_ff == MODE_ALARM) begin
         lo = STAT_LOW;
         hi = STAT_HIGH;
      end
   end

   assign up_sum   = {1'b0, edit_ff} + 7'd1;
   assign adj_up   = (up_sum > {1'b0, hi}) ? lo : up_sum[SIXTY_W-1:0];
   assign down_val = edit_ff - 6'd1;
   assign adj_down = (edit_ff <= lo) ? hi : ((down_val > hi) ? lo : down_val);

   // Datapath
   always_comb begin
      edit_in       = edit_ff;
      cap_min_in    = cap_min_ff;
      cap_sec_in    = cap_sec_ff;
      pend_hour_in  = pend_hour_ff;
      pend_min_in   = pend_min_ff;
      pend_sec_in   = pend_sec_ff;
      alarm_hr_in   = alarm_hr_ff;
      alarm_min_in  = alarm_min_ff;
      alarm_stat_in = alarm_stat_ff;
      pattern_in    = pattern_ff;
      commit_time   = 1'b0;
      commit_alarm  = 1'b0;
      show          = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            case (op)
               OP_TICK: pattern_in = make_pattern(cur_hour, cur_minute, cur_second);
               OP_LEFT: begin
                  edit_in    = {1'b0, cur_hour};
                  cap_min_in = cur_minute;
                  cap_sec_in = cur_second;
                  show       = 1'b1;
               end
               OP_RIGHT: begin
                  edit_in = {1'b0, alarm_hr_ff};
                  show    = 1'b1;
               end
               default: ;
            endcase
         end
         default: begin
            case (op)
               OP_LEFT: begin
                  edit_in = adj_down;
                  show    = 1'b1;
               end
               OP_RIGHT: begin
                  edit_in = adj_up;
                  show    = 1'b1;
               end
               OP_SAVE: begin
                  if (mode_ff == MODE_TIME) begin
                     case (row_ff)
                        ROW_HOUR:   pend_hour_in = edit_ff[HOUR_W-1:0];
                        ROW_MINUTE: pend_min_in  = edit_ff;
                        default:    pend_sec_in  = edit_ff;
                     endcase
                  end else begin
                     case (row_ff)
                        ROW_HOUR:   alarm_hr_in   = edit_ff[HOUR_W-1:0];
                        ROW_MINUTE: alarm_min_in  = edit_ff;
                        default:    alarm_stat_in = edit_ff[1:0];
                     endcase
                  end
                  if (last_row) begin
                     commit_time  = (mode_ff == MODE_TIME);
                     commit_alarm = (mode_ff != MODE_TIME);
                  end else begin
                     // load the next row's starting value
                     if (mode_ff == MODE_TIME) begin
                        edit_in = (row_in == ROW_MINUTE) ? cap_min_ff : cap_sec_ff;
                     end else begin
                        edit_in = (row_in == ROW_MINUTE) ? alarm_min_ff
                                                         : {4'b0, alarm_stat_ff};
                     end
                     show = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      endcase
      if (show) begin
         case (row_in)
            ROW_HOUR:   pattern_in = make_pattern(edit_in[HOUR_W-1:0], '0, '0);
            ROW_MINUTE: pattern_in = make_pattern('0, edit_in, '0);
            ROW_LAST:   pattern_in = make_pattern('0, '0, edit_in);
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         row_ff        <= ROW_NONE;
         edit_ff       <= '0;
         cap_min_ff    <= '0;
         cap_sec_ff    <= '0;
         pend_hour_ff  <= '0;
         pend_min_ff   <= '0;
         pend_sec_ff   <= '0;
         alarm_hr_ff   <= '0;
         alarm_min_ff  <= '0;
         alarm_stat_ff <= STAT_OFF;
         pattern_ff    <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         row_ff        <= row_in;
         edit_ff       <= edit_in;
         cap_min_ff    <= cap_min_in;
         cap_sec_ff    <= cap_sec_in;
         pend_hour_ff  <= pend_hour_in;
         pend_min_ff   <= pend_min_in;
         pend_sec_ff   <= pend_sec_in;
         alarm_hr_ff   <= alarm_hr_in;
         alarm_min_ff  <= alarm_min_in;
         alarm_stat_ff <= alarm_stat_in;
         pattern_ff    <= pattern_in;
      end
   end

   always_comb begin
      result.menu_mode     = mode_in;
      result.edit_row      = row_in;
      result.edit_value    = (mode_in == MODE_IDLE) ? '0 : edit_in;
      result.led_bits      = pattern_in;
      result.commit_time   = commit_time;
      result.set_hour      = pend_hour_in;
      result.set_minute    = pend_min_in;
      result.set_second    = pend_sec_in;
      result.commit_alarm  = commit_alarm;
      result.alarm_hour    = alarm_hr_in;
      result.alarm_minute  = alarm_min_in;
      result.alarm_enabled = (alarm_stat_in == STAT_ON);
   end

endmodule

/* rtl/casm_obuf.sv */
// Result register with a skid stage for the clock/alarm setting menu.
// Depends on casm_pkg.
module casm_obuf
   import casm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rsp_type        push_data,
   output logic           push_ready,
   output logic           out_valid,
   input  logic           out_ready,
   output rsp_type        out_data,
   output buf_status_type status
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop        = out_valid_ff & out_ready;
   assign push_ready = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            // result still waiting downstream: park the new item
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid         = out_valid_ff;
   assign out_data          = out_ff;
   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

/* rtl/clock_alarm_setting_menu_top.sv */
// Three-button time/alarm setting menu for a binary clock, top level.
// Channel ports: req_* carries button/tick events, rsp_* one result per event.
// Each event (tick, left, save, right) comes with the current time; every
// accepted item yields exactly one result item, in order.
// Throughput: one item per cycle while req_tready is high; the menu state and
// the result are worked out in a single pass of compares and muxes, so the
// state registers are never a bottleneck.
// A result register plus one skid entry sit at the output; req_tready drops
// only while both hold results the receiver has not taken, so a stalled
// receiver holds the block after two items.
// Reset: synchronous, active high; clears both output stages, puts the menu
// in idle with the display dark and the alarm status at inactive.
// commit_time / commit_alarm pulse in the result of the save that closes the
// third row; set_* and alarm_* carry the values to write.
`include "assert_macros.svh"

module clock_alarm_setting_menu_top
   import casm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cur_hour[4:0], cur_minute[10:5], cur_second[16:11]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // menu_mode[1:0], edit_row[3:2], edit_value[9:4], led_bits[26:10],
   // commit_time[27], set_hour[32:28], set_minute[38:33], set_second[44:39],
   // commit_alarm[45], alarm_hour[50:46], alarm_minute[56:51], alarm_enabled[57]
   output logic [63:0] rsp_tdata
);

   logic           accept;
   rsp_type        result;
   rsp_type        rsp_item;
   buf_status_type buf_status;

   assign accept = req_tvalid & req_tready;

   casm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (op_type'(req_tuser)),
      .cur_hour   (req_tdata[4:0]),
      .cur_minute (req_tdata[10:5]),
      .cur_second (req_tdata[16:11]),
      .result     (result)
   );

   casm_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_item),
      .status     (buf_status)
   );

   assign rsp_tdata = {6'b0, rsp_item};

   `ASSERT_IMPLY(a_skid_behind_out, buf_status.skid_valid, buf_status.out_valid,
                 "skid entry held while result register empty")
   `ASSERT_IMPLY(a_one_commit, rsp_tvalid,
                 !(rsp_item.commit_time && rsp_item.commit_alarm),
                 "time and alarm commit in one item")
   `ASSERT_IMPLY(a_commit_to_idle, rsp_tvalid && (rsp_item.commit_time || rsp_item.commit_alarm),
                 rsp_item.menu_mode == MODE_IDLE,
                 "commit without return to idle")
   `ASSERT_IMPLY(a_idle_no_edit, rsp_tvalid && rsp_item.menu_mode == MODE_IDLE,
                 rsp_item.edit_row == ROW_NONE && rsp_item.edit_value == '0,
                 "idle result shows an edit row or value")

endmodule
